### rtl/i2r_pkg.sv
// Shared types, constants and letter tables for the integer to Roman encoder.
// Depends on nothing; every other file but i2r_if imports it.
`default_nettype none

package i2r_pkg;

  localparam int unsigned ValueW    = 12;
  localparam int unsigned LetterW   = 7;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 4;

  localparam logic [ValueW-1:0] MaxValue = 12'd3999;

  typedef logic [DigitW-1:0]  digit_t;
  typedef logic [1:0]         pos_t;
  typedef logic [1:0]         step_t;
  typedef logic [2:0]         len_t;
  typedef logic [LetterW-1:0] letter_t;
  typedef logic [ValueW-1:0]  value_t;

  // Positions of the decimal digits
  localparam pos_t PosUnits     = 2'd0;
  localparam pos_t PosTens      = 2'd1;
  localparam pos_t PosHundreds  = 2'd2;
  localparam pos_t PosThousands = 2'd3;

  // ASCII codes
  localparam letter_t ChNone = 7'h00;
  localparam letter_t ChI    = 7'h49;
  localparam letter_t ChV    = 7'h56;
  localparam letter_t ChX    = 7'h58;
  localparam letter_t ChL    = 7'h4C;
  localparam letter_t ChC    = 7'h43;
  localparam letter_t ChD    = 7'h44;
  localparam letter_t ChM    = 7'h4D;

  // One queued item: flags plus the four decimal digits
  typedef struct packed {
    logic                        empty_res;
    logic                        out_of_range;
    logic [NumDigits-1:0][DigitW-1:0] digits;
  } entry_t;

  function automatic letter_t unit_sym(pos_t p);
    letter_t r;
    case (p)
      PosUnits:    r = ChI;
      PosTens:     r = ChX;
      PosHundreds: r = ChC;
      default:     r = ChM;
    endcase
    return r;
  endfunction

  function automatic letter_t five_sym(pos_t p);
    letter_t r;
    case (p)
      PosUnits:    r = ChV;
      PosTens:     r = ChL;
      PosHundreds: r = ChD;
      default:     r = ChNone;
    endcase
    return r;
  endfunction

  function automatic letter_t ten_sym(pos_t p);
    letter_t r;
    case (p)
      PosUnits:    r = ChX;
      PosTens:     r = ChC;
      PosHundreds: r = ChM;
      default:     r = ChNone;
    endcase
    return r;
  endfunction

  // Place value of a digit position
  function automatic value_t pow_of(pos_t p);
    value_t r;
    case (p)
      PosThousands: r = 12'd1000;
      PosHundreds:  r = 12'd100;
      PosTens:      r = 12'd10;
      default:      r = 12'd1;
    endcase
    return r;
  endfunction

  // Number of letters a decimal digit expands to
  function automatic len_t digit_len(digit_t d);
    len_t r;
    case (d)
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd2;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd2;
      4'd7:    r = 3'd3;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Letter number j of digit d at position p
  function automatic letter_t digit_letter(digit_t d, step_t j, pos_t p);
    letter_t r;
    if (d == 4'd4) begin
      r = (j == 2'd0) ? unit_sym(p) : five_sym(p);
    end else if (d == 4'd9) begin
      r = (j == 2'd0) ? unit_sym(p) : ten_sym(p);
    end else if (d >= 4'd5) begin
      r = (j == 2'd0) ? five_sym(p) : unit_sym(p);
    end else begin
      r = unit_sym(p);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/i2r_if.sv
// Valid/ready channel interfaces for the encoder's input and result streams.
// Depends on nothing; the field widths are literals that match i2r_pkg.
`default_nettype none

interface i2r_in_if;
  logic                 valid;
  logic                 ready;
  logic [11:0]          value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if;
  logic                 valid;
  logic                 ready;
  logic [6:0]           letter;
  logic                 last;
  logic                 empty_res;
  logic                 out_of_range;

  modport source (output valid, output letter, output last, output empty_res,
                  output out_of_range, input ready);
  modport sink   (input valid, input letter, input last, input empty_res,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/i2r_front.sv
// Front end: accepts a value when idle, classifies it, splits it into decimal
// digits (tens and units in one step). Depends on i2r_pkg and i2r_in_if.
`default_nettype none

module i2r_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  i2r_in_if.sink             in_i,
  output logic               push_o,
  output i2r_pkg::entry_t    entry_o,
  input  wire logic          full_i
);
  import i2r_pkg::*;

  // Multiples of the place value reach 9000, wider than a value
  localparam int unsigned KpW = ValueW + 2;

  typedef enum logic [2:0] {
    FsIdle = 3'b001,
    FsDiv  = 3'b010,
    FsPush = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  value_t       rem_q, rem_d;
  pos_t         pos_q, pos_d;
  entry_t       entry_q, entry_d;

  value_t       pw;
  logic [KpW-1:0] kp;
  value_t       sub;
  digit_t       dig;
  value_t       rem_nxt;

  assign in_i.ready = (state_q == FsIdle);
  assign push_o     = (state_q == FsPush) && !full_i;
  assign entry_o    = entry_q;

  // One digit step: largest multiple of the place value not above the remainder
  always_comb begin
    pw  = pow_of(pos_q);
    dig = '0;
    sub = '0;
    kp  = '0;
    for (int k = 1; k <= 9; k++) begin
      kp = KpW'(int'(pw) * k);
      if ({2'b00, rem_q} >= kp) begin
        dig = DigitW'(k);
        sub = kp[ValueW-1:0];
      end
    end
    rem_nxt = rem_q - sub;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    entry_d = entry_q;
    case (state_q)
      FsIdle: begin
        if (in_i.valid) begin
          entry_d = '0;
          if (in_i.value == '0) begin
            entry_d.empty_res = 1'b1;
            state_d           = FsPush;
          end else if (in_i.value > MaxValue) begin
            entry_d.out_of_range = 1'b1;
            state_d              = FsPush;
          end else begin
            rem_d   = in_i.value;
            pos_d   = PosThousands;
            state_d = FsDiv;
          end
        end
      end
      FsDiv: begin
        entry_d.digits[pos_q] = dig;
        rem_d                 = rem_nxt;
        if (pos_q == PosTens) begin
          entry_d.digits[PosUnits] = rem_nxt[DigitW-1:0];
          state_d                  = FsPush;
        end else begin
          pos_d = pos_q - 2'd1;
        end
      end
      FsPush: begin
        if (!full_i) begin
          state_d = FsIdle;
        end
      end
      default: begin
        state_d = FsIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

### rtl/i2r_queue.sv
// Short FIFO of digit entries between front and back end.
// Depends on i2r_pkg.
`default_nettype none

module i2r_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire i2r_pkg::entry_t entry_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output i2r_pkg::entry_t    entry_o
);
  import i2r_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

### rtl/i2r_back.sv
// Back end: walks one entry's digits and, unless out_o stalls, puts one
// letter per cycle in an output register. Needs i2r_pkg and i2r_out_if.
`default_nettype none

module i2r_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire i2r_pkg::entry_t entry_i,
  output logic                 pop_o,
  i2r_out_if.source            out_o
);
  import i2r_pkg::*;

  logic    busy_q;
  entry_t  cur_q;
  pos_t    pos_q;
  step_t   step_q;

  logic    out_valid_q;
  letter_t letter_q;
  logic    last_q;
  logic    empty_q;
  logic    oor_q;

  digit_t  cur_dig;
  len_t    cur_len;
  logic    special;
  logic    has_lower;
  pos_t    nxt_pos;
  pos_t    start_pos;
  logic    step_last;
  logic    last_letter;
  logic    emit;
  logic    load;

  // Current digit and where to go next
  always_comb begin
    cur_dig   = cur_q.digits[pos_q];
    cur_len   = digit_len(cur_dig);
    special   = cur_q.empty_res || cur_q.out_of_range;
    has_lower = 1'b0;
    nxt_pos   = PosUnits;
    for (int p = 0; p < NumDigits; p++) begin
      if ((pos_t'(p) < pos_q) && (cur_q.digits[p] != '0)) begin
        has_lower = 1'b1;
        nxt_pos   = pos_t'(p);
      end
    end
    start_pos = PosUnits;
    for (int p = 0; p < NumDigits; p++) begin
      if (entry_i.digits[p] != '0) begin
        start_pos = pos_t'(p);
      end
    end
    step_last   = (({1'b0, step_q} + 3'd1) == cur_len);
    last_letter = special || (step_last && !has_lower);
    emit        = busy_q && (!out_valid_q || out_o.ready);
    load        = valid_i && (!busy_q || (emit && last_letter));
  end

  assign pop_o = load;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit && last_letter) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Walk state and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= entry_i;
      pos_q  <= start_pos;
      step_q <= '0;
    end else if (emit && !last_letter) begin
      if (step_last) begin
        pos_q  <= nxt_pos;
        step_q <= '0;
      end else begin
        step_q <= step_q + 2'd1;
      end
    end
    if (emit) begin
      letter_q <= special ? ChNone : digit_letter(cur_dig, step_q, pos_q);
      last_q   <= last_letter;
      empty_q  <= cur_q.empty_res;
      oor_q    <= cur_q.out_of_range;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.letter       = letter_q;
  assign out_o.last         = last_q;
  assign out_o.empty_res    = empty_q;
  assign out_o.out_of_range = oor_q;

endmodule

`default_nettype wire

### rtl/integer_to_roman_encoder_top.sv
// Integer to Roman numeral encoder, top level.
// Input channel in_i carries a 12-bit value; output channel out_o carries one
// ASCII letter per item with last, empty_res and out_of_range marks. Both are
// valid/ready; an item moves when valid and ready are high at a clock edge.
// A value of 1..3999 yields its numeral, most significant letter first, last
// set on the final letter. Zero yields one item with empty_res set and letter
// 0; a value above 3999 yields one item with out_of_range set and letter 0.
// The front end handles a value in steps (accept, three digit-split steps, queue
// write; zero and out-of-range values go straight from accept to the queue
// write) and then waits for the next value; the back end issues one letter per
// cycle while out_o is not stalled. The longest numeral has 15 letters. The
// entry queue (QueueDepth entries; the user must keep this at least 2, the
// block does not check it) lets the front end run ahead of the back end.
// A stall on out_o holds the output register; the back end stops, the queue
// fills, and then in_i.ready drops. Reset empties the queue and the output.
// Depends on i2r_pkg, i2r_if, i2r_front, i2r_queue and i2r_back.
`default_nettype none

module integer_to_roman_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  i2r_in_if.sink    in_i,
  i2r_out_if.source out_o
);
  import i2r_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t head_entry;

  i2r_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  i2r_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  i2r_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### tb/tb_integer_to_roman_encoder_top.sv
// Self-checking testbench for integer_to_roman_encoder_top: values in, numeral letters out.
// Needs i2r_pkg, i2r_if and the encoder RTL. A built-in predictor spells each value
// and every output item is compared against it.
`timescale 1ns / 1ps

module tb_integer_to_roman_encoder_top;
  import i2r_pkg::*;

  localparam int unsigned NumRandom  = 480;
  localparam int unsigned HoldAt     = 200;  // accepted values before the long output stall
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 30;
  localparam int unsigned MaxReports = 10;

  // One expected output item
  typedef struct {
    letter_t letter;
    logic    last;
    logic    empty_res;
    logic    out_of_range;
  } numeral_res_t;

  // One value to send; drain_first holds it back until all letters are out
  typedef struct {
    value_t value;
    bit     drain_first;
  } value_item_t;

  typedef enum int {RxOpen, RxHalf, RxSparse, RxEveryThird} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  i2r_in_if  in_ch ();
  i2r_out_if out_ch ();

  integer_to_roman_encoder_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  value_item_t  values_to_send[$];
  numeral_res_t letters_due[$];

  bit          in_fire   = 1'b0;
  int unsigned in_count  = 0;
  int unsigned fail_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned rx_cycle   = 0;
  rx_mode_e    rx_mode    = RxOpen;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Letters in order of scale: I V X L C D M
  function automatic letter_t scale_letter(int idx);
    letter_t ch;
    case (idx)
      0:       ch = ChI;
      1:       ch = ChV;
      2:       ch = ChX;
      3:       ch = ChL;
      4:       ch = ChC;
      5:       ch = ChD;
      6:       ch = ChM;
      default: ch = ChNone;
    endcase
    return ch;
  endfunction

  // Spell a value and queue the letters it should produce
  function automatic void spell_numeral(value_t v);
    letter_t      word[$];
    numeral_res_t r;
    int unsigned  place;
    int unsigned  d;
    int unsigned  k;
    int           p;
    r.letter       = ChNone;
    r.last         = 1'b1;
    r.empty_res    = (v == 0);
    r.out_of_range = (v > MaxValue);
    if (v == 0 || v > MaxValue) begin
      letters_due.push_back(r);
      return;
    end
    place = 1000;
    for (p = 3; p >= 0; p--) begin
      d = (v / place) % 10;
      if (d == 9) begin
        word.push_back(scale_letter(2 * p));
        word.push_back(scale_letter(2 * p + 2));
      end else if (d == 4) begin
        word.push_back(scale_letter(2 * p));
        word.push_back(scale_letter(2 * p + 1));
      end else begin
        if (d >= 5) word.push_back(scale_letter(2 * p + 1));
        for (k = 0; k < d % 5; k++) word.push_back(scale_letter(2 * p));
      end
      place = place / 10;
    end
    for (int i = 0; i < word.size(); i++) begin
      r.letter       = word[i];
      r.last         = (i == word.size() - 1);
      r.empty_res    = 1'b0;
      r.out_of_range = 1'b0;
      letters_due.push_back(r);
    end
  endfunction

  // Random value: mostly in range, some long numerals, zeros and overflows
  function automatic value_t pick_value();
    int unsigned sel;
    value_t      v;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      v = '0;
    end else if (sel < 12) begin
      v = value_t'($urandom_range(4000, 4095));
    end else if (sel < 24) begin
      // digits 7 and 8 give the longest letter runs
      v = value_t'($urandom_range(0, 3) * 1000 + (7 + $urandom_range(0, 1)) * 100
                   + (7 + $urandom_range(0, 1)) * 10 + (7 + $urandom_range(0, 1)));
    end else begin
      v = value_t'($urandom_range(1, 3999));
    end
    return v;
  endfunction

  // Sampling at the rising edge: check letters, then predict for new values
  always @(posedge clk) begin
    numeral_res_t exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (letters_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("%0t: unexpected letter %h last %b empty %b oor %b", $realtime,
                     out_ch.letter, out_ch.last, out_ch.empty_res, out_ch.out_of_range);
        end else begin
          exp_r = letters_due.pop_front();
          if (out_ch.letter !== exp_r.letter || out_ch.last !== exp_r.last ||
              out_ch.empty_res !== exp_r.empty_res ||
              out_ch.out_of_range !== exp_r.out_of_range) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports)
              $display("%0t: mismatch exp letter %h last %b empty %b oor %b, got %h %b %b %b",
                       $realtime, exp_r.letter, exp_r.last, exp_r.empty_res,
                       exp_r.out_of_range, out_ch.letter, out_ch.last, out_ch.empty_res,
                       out_ch.out_of_range);
          end
        end
      end
      in_fire = in_ch.valid && in_ch.ready;
      if (in_fire) begin
        spell_numeral(in_ch.value);
        in_count++;
      end
    end
  end

  // Value driver: bursts with random gaps, fed from the send queue
  always @(negedge clk) begin
    logic   nxt_valid;
    value_t nxt_value;
    nxt_valid = in_ch.valid;
    nxt_value = in_ch.value;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_ch.valid && in_fire) begin
        nxt_valid = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (values_to_send.size() != 0 &&
                     !(values_to_send[0].drain_first && letters_due.size() != 0)) begin
          nxt_value = values_to_send[0].value;
          void'(values_to_send.pop_front());
          nxt_valid = 1'b1;
        end
      end
    end
    in_ch.valid <= nxt_valid;
    in_ch.value <= nxt_value;
  end

  // Letter receiver: random stall patterns, plus one long hold-off
  always @(negedge clk) begin
    logic nxt_ready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      nxt_ready = 1'b0;
    end else if (!hold_done && in_count >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      nxt_ready = 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RxOpen:   nxt_ready = 1'b1;
        RxHalf:   nxt_ready = ($urandom_range(0, 1) == 0);
        RxSparse: nxt_ready = ($urandom_range(0, 3) == 0);
        default:  nxt_ready = (rx_cycle % 3 != 0);
      endcase
    end
    out_ch.ready <= nxt_ready;
  end

  // Stimulus, reset and end of run
  initial begin
    value_item_t it;
    value_t      directed[$];
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;

    // zero, subtractive forms, digit boundaries, longest numeral, range edges, bit patterns
    directed = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd49, 12'd90,
                 12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000, 12'd1994,
                 12'd3000, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2048,
                 12'd1365, 12'd2730, 12'd0};
    foreach (directed[i]) begin
      it.value       = directed[i];
      it.drain_first = 1'b0;
      values_to_send.push_back(it);
    end
    for (int i = 0; i < NumRandom; i++) begin
      it.value = pick_value();
      // sender waits for the output to run dry at a few points
      it.drain_first = (i == 0 || i == 120 || i == 350);
      values_to_send.push_back(it);
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (values_to_send.size() != 0 || in_ch.valid) @(posedge clk);
    while (letters_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(4_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
